// File: design/frame_crc16_checker_assert.svh
// Assertion macros shared by the frame CRC checker RTL.
// Each macro expects aclk and aresetn to exist in the including module.
`ifndef FRAME_CRC16_CHECKER_ASSERT_SVH
`define FRAME_CRC16_CHECKER_ASSERT_SVH

// Same-cycle implication, quiet while reset is asserted.
`define FCC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet while reset is asserted.
`define FCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/fcc_pkg.sv
// Shared types, constants and the CRC-16/MODBUS byte update for the frame checker.
// No dependencies.
`default_nettype none

package fcc_pkg;

    localparam int unsigned HEADER_BYTES = 4;
    localparam int unsigned POS_W        = 9;
    localparam logic [POS_W-1:0] POS_MAX = 9'd511;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_SHORT    = 2'd1;
    localparam logic [1:0] STATUS_MISMATCH = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_frame;
    } fcc_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] payload_length;
    } fcc_out_t;

    // Reflected CRC-16 update over one byte, least significant bit first.
    function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: design/fcc_in_stage.sv
// Input register for the frame checker: holds one byte request until it is consumed.
// Depends on fcc_pkg.
`default_nettype none

module fcc_in_stage
    import fcc_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire fcc_in_t s_payload,
    input  wire logic    advance,
    output logic         item_valid,
    output fcc_in_t      item
);

    logic    valid_reg;
    fcc_in_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (advance) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_payload;
        end
    end

endmodule

`default_nettype wire

// File: design/fcc_frame_track.sv
// Frame state for the checker: byte position, length, running CRC and verdict.
// Depends on fcc_pkg and frame_crc16_checker_assert.svh.
`default_nettype none

module fcc_frame_track
    import fcc_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire fcc_in_t item,
    input  wire logic    advance,
    output fcc_out_t     result
);

    typedef enum logic [1:0] {
        V_PENDING,
        V_OK,
        V_MISMATCH
    } verdict_t;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       len_reg, len_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       crc_low_reg, crc_low_next;
    verdict_t         verdict_reg, verdict_next;
    logic [POS_W-1:0] crc_end;
    logic [15:0]      rx_crc;

    always_comb begin
        len_next     = (pos_reg == POS_W'(3)) ? item.data_byte : len_reg;
        crc_end      = POS_W'(HEADER_BYTES) + {1'b0, len_next};
        crc_next     = crc_reg;
        crc_low_next = crc_low_reg;
        verdict_next = verdict_reg;
        rx_crc       = {item.data_byte, crc_low_reg};

        if (verdict_reg == V_PENDING) begin
            if (pos_reg < crc_end) begin
                crc_next = crc16_feed(crc_reg, item.data_byte);
            end else if (pos_reg == crc_end) begin
                crc_low_next = item.data_byte;
            end else if (pos_reg == crc_end + POS_W'(1)) begin
                verdict_next = (rx_crc == crc_reg) ? V_OK : V_MISMATCH;
            end
        end

        pos_next = (pos_reg < POS_MAX) ? pos_reg + POS_W'(1) : pos_reg;

        case (verdict_next)
            V_OK:       result.status = STATUS_OK;
            V_MISMATCH: result.status = STATUS_MISMATCH;
            default:    result.status = STATUS_SHORT;
        endcase
        result.payload_length = len_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (advance && item.end_of_frame)) begin
            pos_reg     <= '0;
            len_reg     <= '0;
            crc_reg     <= CRC_INIT;
            crc_low_reg <= '0;
            verdict_reg <= V_PENDING;
        end else if (advance) begin
            pos_reg     <= pos_next;
            len_reg     <= len_next;
            crc_reg     <= crc_next;
            crc_low_reg <= crc_low_next;
            verdict_reg <= verdict_next;
        end
    end

`include "frame_crc16_checker_assert.svh"

    // A verdict exists only once both CRC bytes have gone by.
    `FCC_ASSERT_NOW(a_verdict_after_crc, verdict_reg != V_PENDING, pos_reg >= ({1'b0, len_reg} + POS_W'(HEADER_BYTES + 2)), "verdict set before CRC bytes")
    // The length field stays zero until byte 3 has been taken.
    `FCC_ASSERT_NOW(a_len_before_hdr, pos_reg <= POS_W'(3), len_reg == 8'd0, "length captured too early")
    // Ending a frame restarts the position and the CRC.
    `FCC_ASSERT_NEXT(a_frame_restart, advance && item.end_of_frame, pos_reg == '0 && crc_reg == CRC_INIT && verdict_reg == V_PENDING, "frame state not restarted")

endmodule

`default_nettype wire

// File: design/fcc_out_stage.sv
// Result register for the frame checker: holds one result until the sink takes it.
// Depends on fcc_pkg.
`default_nettype none

module fcc_out_stage
    import fcc_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     load,
    input  wire fcc_out_t result,
    output logic          free,
    output logic          m_valid,
    input  wire logic     m_ready,
    output fcc_out_t      m_payload
);

    logic     valid_reg;
    fcc_out_t data_reg;

    // The register can take a new result when empty or when it is being drained now.
    assign free      = !valid_reg || m_ready;
    assign m_valid   = valid_reg;
    assign m_payload = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

endmodule

`default_nettype wire

// File: design/frame_crc16_checker.sv
// Top level of the CRC-16/MODBUS frame checker.
// Depends on fcc_pkg, fcc_in_stage, fcc_frame_track and fcc_out_stage.
//
//   Channel   Ports                          Carries
//   input     s_valid, s_ready, s_payload    one frame byte and its last-byte flag
//   result    m_valid, m_ready, m_payload    status and payload length, one per frame
//
// One byte is taken per cycle while no last byte waits; each frame's result is registered.
// The running CRC is updated by eight unrolled bit steps in the single stage between the
// input register and the state/result registers. Reset is synchronous on aresetn and
// clears the frame state. Only a last byte waits on a full result register; other bytes
// keep flowing while a result is held.
`default_nettype none

module frame_crc16_checker
    import fcc_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire fcc_in_t s_payload,
    output logic         m_valid,
    input  wire logic    m_ready,
    output fcc_out_t     m_payload
);

    logic     item_valid;
    fcc_in_t  item;
    logic     advance;
    logic     out_free;
    fcc_out_t result;

    assign advance = item_valid && (!item.end_of_frame || out_free);

    fcc_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_payload  (s_payload),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    fcc_frame_track u_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (item),
        .advance (advance),
        .result  (result)
    );

    fcc_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance && item.end_of_frame),
        .result    (result),
        .free      (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

`default_nettype wire

// File: tb/fcc_tb_pkg.sv
// Scoreboard for the frame CRC checker testbench: a byte-level model of the
// frame check and the queue of verdicts it predicts. Depends on fcc_pkg.
package fcc_tb_pkg;
    import fcc_pkg::*;

    typedef enum logic [1:0] {
        VERDICT_PENDING,
        VERDICT_OK,
        VERDICT_MISMATCH
    } verdict_e;

    // CRC-16/MODBUS over one byte, shifting the data in one bit at a time, LSB first.
    function automatic logic [15:0] modbus_crc_byte(input logic [15:0] crc,
                                                    input logic [7:0] b);
        logic [15:0] r;
        r = crc;
        for (int i = 0; i < 8; i++) begin
            if (r[0] ^ b[i]) begin
                r = (r >> 1) ^ CRC_POLY;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    class frame_verdict_board;
        logic [POS_W-1:0] byte_pos;
        logic [7:0]       length_seen;
        logic [15:0]      crc_acc;
        logic [7:0]       crc_low;
        verdict_e         verdict;
        fcc_out_t         verdicts_due[$];
        int unsigned      bad_verdicts;

        function new();
            bad_verdicts = 0;
            restart();
        endfunction

        function void restart();
            byte_pos    = '0;
            length_seen = '0;
            crc_acc     = CRC_INIT;
            crc_low     = '0;
            verdict     = VERDICT_PENDING;
        endfunction

        function int unsigned pending();
            return verdicts_due.size();
        endfunction

        // Advances the frame state by one accepted byte; a last byte yields a verdict.
        function void take_byte(input fcc_in_t req);
            logic [9:0] crc_end;
            fcc_out_t   v;
            if (byte_pos == 3) begin
                length_seen = req.data_byte;
            end
            crc_end = 10'(HEADER_BYTES) + 10'(length_seen);
            if (verdict == VERDICT_PENDING) begin
                if ({1'b0, byte_pos} < crc_end) begin
                    crc_acc = modbus_crc_byte(crc_acc, req.data_byte);
                end else if ({1'b0, byte_pos} == crc_end) begin
                    crc_low = req.data_byte;
                end else if ({1'b0, byte_pos} == crc_end + 10'd1) begin
                    verdict = ({req.data_byte, crc_low} == crc_acc) ? VERDICT_OK
                                                                     : VERDICT_MISMATCH;
                end
            end
            // The position sticks at its maximum so that byte 3 is never seen twice.
            if (byte_pos != POS_MAX) begin
                byte_pos = byte_pos + 1'b1;
            end
            if (req.end_of_frame) begin
                case (verdict)
                    VERDICT_OK:       v.status = STATUS_OK;
                    VERDICT_MISMATCH: v.status = STATUS_MISMATCH;
                    default:          v.status = STATUS_SHORT;
                endcase
                v.payload_length = length_seen;
                verdicts_due.push_back(v);
                restart();
            end
        endfunction

        function void check_verdict(input fcc_out_t got);
            fcc_out_t want;
            if (verdicts_due.size() == 0) begin
                bad_verdicts++;
                if (bad_verdicts <= 10) begin
                    $display("ERROR: unexpected result status=%0d length=%0d",
                             got.status, got.payload_length);
                end
                return;
            end
            want = verdicts_due.pop_front();
            if (got.status !== want.status || got.payload_length !== want.payload_length) begin
                bad_verdicts++;
                if (bad_verdicts <= 10) begin
                    $display("ERROR: expected status=%0d length=%0d, got status=%0d length=%0d",
                             want.status, want.payload_length, got.status, got.payload_length);
                end
            end
        endfunction
    endclass

endpackage

// File: tb/frame_crc16_checker_test.sv
// Top-level testbench for frame_crc16_checker: drives framed byte streams with
// random gaps and stalls and checks every verdict. Depends on fcc_pkg and fcc_tb_pkg.
module frame_crc16_checker_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fcc_pkg::*;
    import fcc_tb_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned PHASE_BYTES  = 100;

    logic     aclk      = 1'b0;
    logic     aresetn   = 1'b0;
    logic     s_valid   = 1'b0;
    logic     s_ready;
    fcc_in_t  s_payload = '0;
    logic     m_valid;
    logic     m_ready   = 1'b0;
    fcc_out_t m_payload;

    frame_verdict_board board = new();

    int unsigned cycle_count     = 0;
    int unsigned idle_pct        = 0;
    int unsigned stall_pct       = 0;
    int unsigned hold_off_cycles = 0;
    int unsigned bytes_counted   = 0;
    logic [7:0]  frame_buf[$];

    frame_crc16_checker DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_verdict(m_payload);
        end
    end

    // A requested hold-off keeps ready low until its count runs out, ahead of random stalls.
    always @(negedge aclk) begin
        if (hold_off_cycles != 0) begin
            m_ready <= 1'b0;
            hold_off_cycles--;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Entered just after a rising edge or at a falling edge; returns at the accepting edge.
    task automatic offer_byte(input logic [7:0] b, input logic is_last);
        fcc_in_t req;
        req.data_byte    = b;
        req.end_of_frame = is_last;
        @(negedge aclk);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= req;
        do @(posedge aclk); while (!s_ready);
        board.take_byte(req);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (board.pending() != 0) begin
            @(negedge aclk);
        end
    endtask

    // Header bytes 0..2 random, byte 3 the length, then payload and a correct CRC.
    function automatic void build_frame(input logic [7:0] plen);
        logic [15:0] crc;
        frame_buf = {};
        crc = CRC_INIT;
        for (int i = 0; i < 4 + plen; i++) begin
            frame_buf.push_back((i == 3) ? plen : 8'($urandom));
            crc = modbus_crc_byte(crc, frame_buf[i]);
        end
        frame_buf.push_back(crc[7:0]);
        frame_buf.push_back(crc[15:8]);
    endfunction

    // Sends the buffered frame with the last-byte flag on its final byte. Only the
    // first 'counted' bytes count toward the stimulus budget.
    task automatic send_frame(input int unsigned counted);
        for (int i = 0; i < frame_buf.size(); i++) begin
            offer_byte(frame_buf[i], i == frame_buf.size() - 1);
            if (i < counted) begin
                bytes_counted++;
            end
        end
    endtask

    task automatic send_random_frame();
        int unsigned kind;
        int unsigned cut;
        logic [7:0]  plen;
        logic [15:0] flip;
        kind = $urandom_range(99);
        plen = ($urandom_range(19) == 0) ? 8'($urandom_range(255, 25)) : 8'($urandom_range(24));
        build_frame(plen);
        if (kind < 70) begin
            cut = frame_buf.size();
            if ($urandom_range(4) == 0) begin
                repeat ($urandom_range(3, 1)) frame_buf.push_back(8'($urandom));
            end
        end else if (kind < 82) begin
            flip = 16'($urandom_range(65535, 1));
            frame_buf[4 + plen] ^= flip[7:0];
            frame_buf[5 + plen] ^= flip[15:8];
            cut = frame_buf.size();
        end else if (kind < 92) begin
            // Frame ends somewhere before its CRC is complete.
            cut = $urandom_range(frame_buf.size() - 1, 1);
            frame_buf = frame_buf[0:cut-1];
        end else begin
            frame_buf = {};
            repeat ($urandom_range(10, 1)) frame_buf.push_back(8'($urandom));
            cut = frame_buf.size();
        end
        send_frame(cut);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // A lone last byte, and a frame that stops right after its length byte.
        frame_buf = {8'hFF};
        send_frame(1);
        frame_buf = {8'h00, 8'hFF, 8'h00, 8'hFF};
        send_frame(4);
        // Empty payload: good CRC, bad high byte, bad low byte followed by a trailing byte.
        build_frame(8'h00);
        send_frame(6);
        build_frame(8'h00);
        frame_buf[5] ^= 8'h80;
        send_frame(6);
        build_frame(8'h00);
        frame_buf[4] ^= 8'h01;
        frame_buf.push_back(8'hFF);
        send_frame(6);

        // Largest payload, with enough trailing bytes to push the position past saturation.
        build_frame(8'hFF);
        repeat (260) frame_buf.push_back(8'($urandom));
        send_frame(261);
        wait_drained();

        // Hold results back long enough that last bytes back up at the input.
        hold_off_cycles = 300;
        repeat (20) send_random_frame();
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 65;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 65;
                end
                default: begin
                    idle_pct  = 15;
                    stall_pct = 15;
                end
            endcase
            bytes_counted = 0;
            while (bytes_counted < PHASE_BYTES) begin
                send_random_frame();
            end
            wait_drained();
        end

        repeat (20) @(negedge aclk);
        if (board.bad_verdicts == 0 && board.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
